/* design/tfic_pkg.sv */
// Shared types, constants and helpers of the integrator chain unit.
package tfic_pkg;

  localparam int ORDER_DEF = 4;
  localparam int NCOEF     = 3;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 25;
  localparam int FRAC      = 24;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int RND_W     = PROD_W - FRAC;
  localparam int ACC_W     = 42;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEAD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_3 = 3'd4;

  localparam logic signed [DATA_W-1:0] LEAD_RST = 32'sd16777216;
  localparam logic [STEP_W-1:0]        STEP_RST = 25'd16777;
  localparam logic signed [PROD_W-1:0] RND_HALF = 64'sd8388608;

  localparam logic signed [ACC_W-1:0] SAT_HI = 42'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -42'sd2147483648;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_FB_MUL,
    OP_FB_ACC,
    OP_SC_MUL,
    OP_SC_ACC,
    OP_IT_MUL,
    OP_IT_ACC,
    OP_LOAD_OUT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.val = SAT_HI[DATA_W-1:0];
      r.ovf = 1'b1;
    end else if (v < SAT_LO) begin
      r.val = SAT_LO[DATA_W-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

/* design/transfer_function_integrator_chain_unit.sv */
// Top level of the all-pole transfer function integrator chain unit.
// A request is accepted only in the idle state, so a new request waits until the last one is through;
//   the single shared multiplier and its product register (multiply, then accumulate) set the pace.
// A finished result waits in the output register while the next request is accepted.
// Reset (async, active low): stage values zero, config registers to defaults, no result valid.
module transfer_function_integrator_chain_unit #(
  parameter int ORDER = tfic_pkg::ORDER_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input request channel.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [tfic_pkg::DATA_W-1:0]    sample_in_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [tfic_pkg::DATA_W-1:0]    sample_out_o,
  output logic                                  overflow_o,
  // Configuration write port; the user must write it only while idle, the block does not enforce this.
  input  logic                                  cfg_we_i,
  input  logic [tfic_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tfic_pkg::DATA_W-1:0]           cfg_data_i
);

  // Command bundle from the sequencer: which step of the request runs this cycle,
  // which stage it touches, and whether it is the last of its pass.
  tfic_pkg::cmd_t cmd;

  // Sequencer: feedback pass (multiply, subtract per stage), scale by the lead
  // reciprocal, then the integrator pass in stage order, then hand off the result.
  tfic_ctrl #(
    .ORDER(ORDER)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  // Datapath: holds config and stage values, runs the shared multiplier,
  // rounds, accumulates and saturates, and keeps the output register.
  tfic_dpath #(
    .ORDER(ORDER)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_in_i (sample_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_out_o(sample_out_o),
    .overflow_o  (overflow_o)
  );

endmodule

/* design/tfic_ctrl.sv */
// Sequencer of the integrator chain: steps the shared multiplier through one request.
module tfic_ctrl #(
  parameter int ORDER = tfic_pkg::ORDER_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tfic_pkg::cmd_t cmd_o
);

  localparam int STAGES = ORDER - 1;
  localparam int NFB    = (STAGES < tfic_pkg::NCOEF) ? STAGES : tfic_pkg::NCOEF;
  localparam int IW     = tfic_pkg::IDX_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FB_MUL = 3'd1;
  localparam logic [2:0] S_FB_ACC = 3'd2;
  localparam logic [2:0] S_SC_MUL = 3'd3;
  localparam logic [2:0] S_SC_ACC = 3'd4;
  localparam logic [2:0] S_IT_MUL = 3'd5;
  localparam logic [2:0] S_IT_ACC = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] k_q, k_d;
  logic          out_valid_q, out_valid_d;
  logic          fb_last, it_last, out_free;

  assign fb_last  = (k_q == IW'(NFB - 1));
  assign it_last  = (k_q == IW'(STAGES - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cmd_o.op    = tfic_pkg::OP_NONE;
    cmd_o.idx   = k_q;
    cmd_o.last  = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = tfic_pkg::OP_START;
          k_d      = '0;
          state_d  = S_FB_MUL;
        end
      end
      S_FB_MUL: begin
        cmd_o.op = tfic_pkg::OP_FB_MUL;
        state_d  = S_FB_ACC;
      end
      S_FB_ACC: begin
        cmd_o.op   = tfic_pkg::OP_FB_ACC;
        cmd_o.last = fb_last;
        if (fb_last) begin
          k_d     = '0;
          state_d = S_SC_MUL;
        end else begin
          k_d     = k_q + IW'(1);
          state_d = S_FB_MUL;
        end
      end
      S_SC_MUL: begin
        cmd_o.op = tfic_pkg::OP_SC_MUL;
        state_d  = S_SC_ACC;
      end
      S_SC_ACC: begin
        cmd_o.op = tfic_pkg::OP_SC_ACC;
        k_d      = '0;
        state_d  = S_IT_MUL;
      end
      S_IT_MUL: begin
        cmd_o.op = tfic_pkg::OP_IT_MUL;
        state_d  = S_IT_ACC;
      end
      S_IT_ACC: begin
        cmd_o.op   = tfic_pkg::OP_IT_ACC;
        cmd_o.last = it_last;
        if (it_last) begin
          state_d = S_DONE;
        end else begin
          k_d     = k_q + IW'(1);
          state_d = S_IT_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.op    = tfic_pkg::OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_FB_MUL && k_q == '0))
    else $error("accepted request did not start the feedback pass");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (k_q <= IW'(STAGES - 1)))
    else $error("stage index beyond the chain");

  a_chain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IT_ACC && it_last) |=> (state_q == S_DONE))
    else $error("last integrator update not followed by done");
`endif

endmodule

/* design/tfic_dpath.sv */
// Datapath of the integrator chain: config registers, stage values, shared multiplier.
module tfic_dpath #(
  parameter int ORDER = tfic_pkg::ORDER_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tfic_pkg::cmd_t                        cmd_i,
  input  logic signed [tfic_pkg::DATA_W-1:0]    sample_in_i,
  input  logic                                  cfg_we_i,
  input  logic [tfic_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tfic_pkg::DATA_W-1:0]           cfg_data_i,
  output logic signed [tfic_pkg::DATA_W-1:0]    sample_out_o,
  output logic                                  overflow_o
);

  localparam int STAGES = ORDER - 1;
  localparam int SIW    = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int DW     = tfic_pkg::DATA_W;
  localparam int AW     = tfic_pkg::ACC_W;
  localparam int PW     = tfic_pkg::PROD_W;
  localparam int RW     = tfic_pkg::RND_W;

  logic signed [DW-1:0]          lead_q;
  logic [tfic_pkg::STEP_W-1:0]   step_q;
  logic signed [DW-1:0]          coef_q [tfic_pkg::NCOEF];
  logic signed [DW-1:0]          stage_q [STAGES];
  logic signed [AW-1:0]          acc_q, acc_d;
  logic signed [DW-1:0]          prev_q;
  logic signed [PW-1:0]          prod_q;
  logic                          ovf_q;
  logic signed [DW-1:0]          out_q;
  logic                          out_ovf_q;

  logic [SIW-1:0]                sidx;
  logic signed [DW-1:0]          coef_sel, stage_sel, mul_a, mul_b;
  logic signed [PW-1:0]          mul_p, prod_rnd;
  logic signed [RW-1:0]          rnd;
  tfic_pkg::sat_t                acc_sat, sc_sat, it_sat;

  assign sidx      = cmd_i.idx[SIW-1:0];
  assign stage_sel = stage_q[sidx];

  always_comb begin
    coef_sel = '0;
    for (int j = 0; j < tfic_pkg::NCOEF; j++) begin
      if (int'(cmd_i.idx) == j) coef_sel = coef_q[j];
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (cmd_i.op)
      tfic_pkg::OP_FB_MUL: begin
        mul_a = coef_sel;
        mul_b = stage_sel;
      end
      tfic_pkg::OP_SC_MUL: begin
        mul_a = lead_q;
        mul_b = prev_q;
      end
      default: begin
        mul_a = prev_q;
        mul_b = $signed({{(DW - tfic_pkg::STEP_W){1'b0}}, step_q});
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  // Round half up to Q8.24.
  assign prod_rnd = prod_q + tfic_pkg::RND_HALF;
  assign rnd      = $signed(prod_rnd[PW-1:tfic_pkg::FRAC]);

  assign acc_d   = acc_q - AW'(rnd);
  assign acc_sat = tfic_pkg::sat32(acc_d);
  assign sc_sat  = tfic_pkg::sat32(AW'(rnd));
  assign it_sat  = tfic_pkg::sat32(AW'(stage_sel) + AW'(rnd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= tfic_pkg::LEAD_RST;
      step_q <= tfic_pkg::STEP_RST;
      for (int j = 0; j < tfic_pkg::NCOEF; j++) coef_q[j] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tfic_pkg::REG_LEAD:   lead_q    <= $signed(cfg_data_i);
        tfic_pkg::REG_STEP:   step_q    <= cfg_data_i[tfic_pkg::STEP_W-1:0];
        tfic_pkg::REG_COEF_1: coef_q[0] <= $signed(cfg_data_i);
        tfic_pkg::REG_COEF_2: coef_q[1] <= $signed(cfg_data_i);
        tfic_pkg::REG_COEF_3: coef_q[2] <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < STAGES; j++) stage_q[j] <= '0;
    end else if (cmd_i.op == tfic_pkg::OP_IT_ACC) begin
      stage_q[sidx] <= it_sat.val;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      tfic_pkg::OP_START: begin
        acc_q <= AW'(sample_in_i);
        ovf_q <= 1'b0;
      end
      tfic_pkg::OP_FB_MUL, tfic_pkg::OP_SC_MUL, tfic_pkg::OP_IT_MUL: begin
        prod_q <= mul_p;
      end
      tfic_pkg::OP_FB_ACC: begin
        acc_q <= acc_d;
        if (cmd_i.last) begin
          prev_q <= acc_sat.val;
          ovf_q  <= ovf_q | acc_sat.ovf;
        end
      end
      tfic_pkg::OP_SC_ACC: begin
        prev_q <= sc_sat.val;
        ovf_q  <= ovf_q | sc_sat.ovf;
      end
      tfic_pkg::OP_IT_ACC: begin
        prev_q <= it_sat.val;
        ovf_q  <= ovf_q | it_sat.ovf;
      end
      tfic_pkg::OP_LOAD_OUT: begin
        out_q     <= stage_q[STAGES-1];
        out_ovf_q <= ovf_q;
      end
      default: ;
    endcase
  end

  assign sample_out_o = out_q;
  assign overflow_o   = out_ovf_q;

endmodule
